// ----- design/range_min_segment_tree_assert.svh -----
// Assertion macros for the RTL, used by range_min_segment_tree.sv.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_ASSERT_SVH

// Same-cycle implication.
`define RMST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rmst_pkg.sv -----
package rmst_pkg;

  // Field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  // Empty-range answer and reset value of every node
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_WR_LEAF,
    ST_WR_UP,
    ST_Q_A,
    ST_Q_B,
    ST_Q_OUT
  } state_t;

endpackage

// ----- design/rmst_node_ram.sv -----
module rmst_node_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [rmst_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr,
  output logic signed [rmst_pkg::VAL_W-1:0] rdata_r
);
  import rmst_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- design/rmst_min.sv -----
module rmst_min (
  input  logic signed [rmst_pkg::VAL_W-1:0] op_a,
  input  logic signed [rmst_pkg::VAL_W-1:0] op_b,
  output logic signed [rmst_pkg::VAL_W-1:0] res
);
  import rmst_pkg::*;

  // signed minimum, shared by tree refresh and query accumulation
  always_comb begin
    res = (op_a < op_b) ? op_a : op_b;
  end

endmodule

// ----- design/range_min_segment_tree.sv -----
// Channel   Ports                                         Handshake
// input     in_cmd in_index in_value in_left in_right     start & !busy
// result    out_min_value                                 out_valid, one cycle
//
// Write word: the leaf is written first, then each tree level in turn
//   (read sibling, min, write parent) up to the root, with busy high.
// Query word: per level, one node-RAM read for each side, then a last
//   bound check and an output state; an empty range goes from the bound
//   check straight to the output state.
// Write with index past the end is dropped and busy never rises.
// After reset the whole node RAM is swept to INT_MAX with busy high.
// The result strobe is not stalled; the next word may start while it shows.
`include "range_min_segment_tree_assert.svh"

module range_min_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [rmst_pkg::IDX_W-1:0]        in_index,
  input  logic signed [rmst_pkg::VAL_W-1:0] in_value,
  input  logic [rmst_pkg::IDX_W-1:0]        in_left,
  input  logic [rmst_pkg::IDX_W-1:0]        in_right,
  output logic                              out_valid,
  output logic signed [rmst_pkg::VAL_W-1:0] out_min_value
);
  import rmst_pkg::*;

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  // range bounds need room for 2*LEAVES and for the raw field widths
  localparam int CW    = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;

  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ONE_A    = AW'(1);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           k_r, k_nxt;
  logic [CW-1:0]           a_r, a_nxt;
  logic [CW-1:0]           b_r, b_nxt;
  logic signed [VAL_W-1:0] acc_r, acc_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_min_r, out_min_nxt;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;
  logic signed [VAL_W-1:0] min_res;

  logic [CW-1:0]           idx_ext, lo_ext, hi_ext, hi_clamp;
  logic [CW-1:0]           leaf_pos, qa_start, qb_start;
  logic                    q_empty;
  logic [AW-1:0]           parent;

  rmst_node_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // the one compare unit: accumulator against the word just read
  rmst_min u_min (
    .op_a (acc_r),
    .op_b (mem_rdata),
    .res  (min_res)
  );

  // decode of incoming fields
  always_comb begin
    idx_ext  = {{(CW-IDX_W){1'b0}}, in_index};
    lo_ext   = {{(CW-IDX_W){1'b0}}, in_left};
    hi_ext   = {{(CW-IDX_W){1'b0}}, in_right};
    hi_clamp = (hi_ext >= LEAVES_C) ? (LEAVES_C - ONE_C) : hi_ext;
    q_empty  = (lo_ext >= LEAVES_C) || (lo_ext > hi_ext);
    leaf_pos = idx_ext + LEAVES_C;
    qa_start = lo_ext + LEAVES_C;
    qb_start = hi_clamp + LEAVES_C + ONE_C;
    parent   = k_r >> 1;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    out_min_r <= out_min_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_min_nxt   = out_min_r;
    mem_we        = 1'b0;
    mem_waddr     = k_r;
    mem_wdata     = acc_r;
    mem_raddr     = k_r ^ ONE_A;

    // fold in the node read last cycle during a query
    if (pend_r) begin
      acc_nxt = min_res;
    end

    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = INT_MAX;
        cnt_nxt   = cnt_r + ONE_A;
        if (cnt_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_WRITE) begin
            if (idx_ext < LEAVES_C) begin
              k_nxt     = leaf_pos[AW-1:0];
              acc_nxt   = in_value;
              state_nxt = ST_WR_LEAF;
            end
          end else begin
            acc_nxt   = INT_MAX;
            a_nxt     = q_empty ? '0 : qa_start;
            b_nxt     = q_empty ? '0 : qb_start;
            state_nxt = ST_Q_A;
          end
        end
      end
      // write leaf, fetch its sibling
      ST_WR_LEAF: begin
        mem_we    = 1'b1;
        state_nxt = ST_WR_UP;
      end
      // parent = min(this, sibling), fetch parent's sibling
      ST_WR_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = min_res;
        mem_raddr = parent ^ ONE_A;
        acc_nxt   = min_res;
        k_nxt     = parent;
        if (parent == ONE_A) begin
          state_nxt = ST_IDLE;
        end
      end
      // left edge of the level
      ST_Q_A: begin
        mem_raddr = a_r[AW-1:0];
        if (a_r < b_r) begin
          if (a_r[0]) begin
            pend_nxt = 1'b1;
            a_nxt    = a_r + ONE_C;
          end
          state_nxt = ST_Q_B;
        end else begin
          state_nxt = ST_Q_OUT;
        end
      end
      // right edge of the level, then climb
      ST_Q_B: begin
        mem_raddr = b_r[AW-1:0] ^ ONE_A;
        if (b_r[0]) begin
          pend_nxt = 1'b1;
        end
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        state_nxt = ST_Q_A;
      end
      ST_Q_OUT: begin
        out_min_nxt   = pend_r ? min_res : acc_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;

  `RMST_ASSERT_NXT(a_out_after_merge, state_r == ST_Q_OUT, out_valid, "result strobe missing")
  `RMST_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `RMST_ASSERT_NXT(a_query_busy, start && !busy && (in_cmd == CMD_QUERY), busy,
                   "query word not taken")
  `RMST_ASSERT_IMP(a_query_no_write, state_r == ST_Q_A || state_r == ST_Q_B, !mem_we,
                   "node write during query")

endmodule

// ----- test/tb_range_min_segment_tree.sv -----
module tb_range_min_segment_tree;
  import rmst_pkg::*;

  localparam int LEAVES = 1024;
  localparam int RANDOM_WORDS = 1700;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 250000;
  localparam int SHOWN_ERRORS = 10;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One input word plus an optional hand-typed answer for queries
  typedef struct {
    logic                    cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
    bit                      known;
    logic signed [VAL_W-1:0] min_exp;
  } tree_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_cmd = CMD_WRITE;
  logic [IDX_W-1:0]        in_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [IDX_W-1:0]        in_left = '0;
  logic [IDX_W-1:0]        in_right = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_min_value;

  // Shadow copy of the min tree: node 1 is the root, leaf i at LEAVES+i
  logic signed [VAL_W-1:0] min_tree [1:2*LEAVES-1];
  logic signed [VAL_W-1:0] expected_mins [$];
  logic signed [VAL_W-1:0] oldest_min;
  tree_word_t              directed_rows [$];
  int                      err_count = 0;
  int                      cycle_count = 0;

  range_min_segment_tree #(.LEAVES(LEAVES)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_index     (in_index),
    .in_value     (in_value),
    .in_left      (in_left),
    .in_right     (in_right),
    .out_valid    (out_valid),
    .out_min_value(out_min_value)
  );

  always #6 clk = ~clk;

  // Point update: set the leaf, then refresh minima up to the root
  function automatic void tree_write(logic [IDX_W-1:0] pos, logic signed [VAL_W-1:0] v);
    int k;
    k = int'(pos) + LEAVES;
    min_tree[k] = v;
    while (k > 1) begin
      k = k >> 1;
      min_tree[k] = (min_tree[2*k] < min_tree[2*k+1]) ? min_tree[2*k] : min_tree[2*k+1];
    end
  endfunction

  // Bottom-up range minimum over lo..hi inclusive
  function automatic logic signed [VAL_W-1:0] tree_range_min(int lo, int hi);
    logic signed [VAL_W-1:0] best;
    int a;
    int b;
    best = INT_MAX;
    if (lo >= LEAVES || lo > hi) return best;
    if (hi >= LEAVES) hi = LEAVES - 1;
    a = lo + LEAVES;
    b = hi + LEAVES + 1;
    while (a < b) begin
      if (a[0]) begin
        if (min_tree[a] < best) best = min_tree[a];
        a++;
      end
      if (b[0]) begin
        b--;
        if (min_tree[b] < best) best = min_tree[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    return best;
  endfunction

  function automatic void add_row(logic cmd, int idx, logic signed [VAL_W-1:0] val, int lo,
                                  int hi, bit known, logic signed [VAL_W-1:0] m);
    tree_word_t w;
    w.cmd = cmd;
    w.index = idx[IDX_W-1:0];
    w.value = val;
    w.left = lo[IDX_W-1:0];
    w.right = hi[IDX_W-1:0];
    w.known = known;
    w.min_exp = m;
    directed_rows.push_back(w);
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return INT_MAX;
      2, 3:    return $signed($urandom_range(0, 100)) - 50;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 5))
      0:       return IDX_W'($urandom_range(0, 31));
      1:       return IDX_W'($urandom_range(LEAVES - 32, LEAVES - 1));
      default: return IDX_W'($urandom_range(0, LEAVES - 1));
    endcase
  endfunction

  // Writes and queries with random content; unused fields carry noise
  function automatic tree_word_t random_word();
    tree_word_t w;
    int a;
    int b;
    w.known = 1'b0;
    w.min_exp = '0;
    w.index = IDX_W'($urandom);
    w.value = $urandom;
    w.left = IDX_W'($urandom);
    w.right = IDX_W'($urandom);
    if ($urandom_range(0, 99) < 45) begin
      w.cmd = CMD_WRITE;
      w.index = random_index();
      w.value = random_value();
    end else begin
      w.cmd = CMD_QUERY;
      a = int'(random_index());
      case ($urandom_range(0, 9))
        0: b = a;
        1: begin a = 0; b = LEAVES - 1; end
        2: b = LEAVES - 1;
        3: begin b = a; a = 0; end
        4, 5: b = (a + $urandom_range(0, 15)) % LEAVES;
        6: b = int'(random_index());
        default: begin
          b = int'(random_index());
          if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
        end
      endcase
      w.left = a[IDX_W-1:0];
      w.right = b[IDX_W-1:0];
    end
    return w;
  endfunction

  // Present a word at the falling edge, hold it until the block takes it
  task automatic send_word(input tree_word_t w);
    @(negedge clk);
    in_cmd <= w.cmd;
    in_index <= w.index;
    in_value <= w.value;
    in_left <= w.left;
    in_right <= w.right;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (w.cmd == CMD_WRITE) begin
      tree_write(w.index, w.value);
    end else begin
      expected_mins.push_back(w.known ? w.min_exp :
                              tree_range_min(int'(w.left), int'(w.right)));
    end
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_mins.size() != 0) @(negedge clk);
  endtask

  // Result check: each strobe against the oldest pending minimum
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_mins.size() == 0) begin
        if (err_count < SHOWN_ERRORS)
          $display("unexpected result word: min_value %0d", out_min_value);
        err_count++;
      end else begin
        oldest_min = expected_mins.pop_front();
        if (out_min_value !== oldest_min) begin
          if (err_count < SHOWN_ERRORS)
            $display("min_value mismatch: expected %0d got %0d", oldest_min, out_min_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL range_min_segment_tree");
      $finish;
    end
  end

  initial begin
    int sent;
    int burst;
    bit paused;
    for (int k = 1; k < 2 * LEAVES; k++) min_tree[k] = INT_MAX;

    // Directed words: empty tree, extremes, reversed ranges, bit patterns
    add_row(CMD_QUERY, 1023, VAL_MIN, 0, 1023, 1'b1, INT_MAX);
    add_row(CMD_QUERY, 0, -1, 1023, 0, 1'b1, INT_MAX);
    add_row(CMD_WRITE, 0, VAL_MIN, 1023, 1023, 1'b0, 0);
    add_row(CMD_WRITE, 1023, INT_MAX, 0, 0, 1'b0, 0);
    add_row(CMD_WRITE, 512, 0, 1023, 0, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1023, 1'b1, VAL_MIN);
    add_row(CMD_QUERY, 0, 0, 1, 1023, 1'b1, 0);
    add_row(CMD_QUERY, 0, 0, 1023, 1023, 1'b1, INT_MAX);
    add_row(CMD_QUERY, 0, 0, 513, 1022, 1'b1, INT_MAX);
    add_row(CMD_WRITE, 1023, -1, 0, 0, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 1023, 1023, 1'b1, -1);
    add_row(CMD_QUERY, 0, 0, 0, 0, 1'b1, VAL_MIN);
    add_row(CMD_QUERY, 0, 0, 1, 0, 1'b1, INT_MAX);
    add_row(CMD_WRITE, 341, 32'sh5555_5555, 0, 0, 1'b0, 0);
    add_row(CMD_WRITE, 682, 32'shAAAA_AAAA, 0, 0, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 341, 341, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 300, 700, 1'b0, 0);
    add_row(CMD_WRITE, 0, INT_MAX, 0, 0, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 511, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1023, 1'b0, 0);
    add_row(CMD_QUERY, 0, 0, 683, 1022, 1'b0, 0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i]);
    drain_results();

    // Random words in bursts, with gaps or back-to-back stretches between
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        send_word(random_word());
        sent++;
      end
      if (!paused && sent >= RANDOM_WORDS / 2) begin
        drain_results();
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_mins.size() == 0) begin
      $display("PASS range_min_segment_tree");
    end else begin
      $display("FAIL range_min_segment_tree");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/rmst_pkg.sv
design/rmst_node_ram.sv
design/rmst_min.sv
design/range_min_segment_tree.sv
test/tb_range_min_segment_tree.sv
